/* hw/rtl/dpd_pkg.sv */
`timescale 1ns / 1ps
// Package of the dual-plate packet deframer: codes, queue entry and result beat types.
// No dependencies; every other file but dpd_if refers to it by scoped names.
package dpd_pkg;

  localparam logic [7:0] MarkerByte = 8'h80;
  localparam int unsigned QueueDepth = 4;
  localparam int unsigned QueueAw = $clog2(QueueDepth);

  typedef enum logic [1:0] {
    KIND_BLOCK = 2'd0,
    KIND_EVENT = 2'd1,
    KIND_ERROR = 2'd2
  } result_kind_e;

  typedef enum logic [1:0] {
    PH_RECORD = 2'd0,
    PH_FIRST  = 2'd1,
    PH_SECOND = 2'd2
  } phase_e;

  localparam logic [1:0] PlateOne = 2'd1;
  localparam logic [1:0] PlateTwo = 2'd2;

  // One packet end or one in-packet marker error, as handed from parser to emitter.
  typedef struct packed {
    logic        is_error;
    logic [31:0] block_number;
    logic [7:0]  busy0;
    logic [7:0]  busy1;
    logic [31:0] count0;
    logic [31:0] count1;
    logic [23:0] factor0;
    logic [23:0] factor1;
    logic        change0;
    logic        change1;
    logic [7:0]  flag0;
    logic [7:0]  flag1;
    logic [55:0] time0;
    logic [55:0] time1;
  } job_t;

  typedef struct packed {
    result_kind_e result_kind;
    logic [31:0]  block_number;
    logic [7:0]   first_busy;
    logic [31:0]  first_count;
    logic [23:0]  first_factor;
    logic [7:0]   second_busy;
    logic [31:0]  second_count;
    logic [23:0]  second_factor;
    logic [1:0]   event_plate;
    logic [7:0]   event_busy;
    logic [55:0]  event_time;
    logic         last;
  } res_t;

  typedef struct packed {
    logic not_empty;
    logic full;
  } queue_status_t;

endpackage

/* hw/rtl/dpd_if.sv */
`timescale 1ns / 1ps
// Handshake channels of the deframer: byte input, configuration write, result output.
// Depends on nothing; payload widths follow the field list.
interface dpd_in_if;
  logic       valid;
  logic       ready;
  logic [7:0] data_byte;
  modport source (output valid, output data_byte, input ready);
  modport sink (input valid, input data_byte, output ready);
endinterface

interface dpd_cfg_if;
  logic       valid;
  logic       ready;
  logic [2:0] data;
  modport source (output valid, output data, input ready);
  modport sink (input valid, input data, output ready);
endinterface

interface dpd_out_if;
  logic        valid;
  logic        ready;
  logic [1:0]  result_kind;
  logic [31:0] block_number;
  logic [7:0]  first_busy;
  logic [31:0] first_count;
  logic [23:0] first_factor;
  logic [7:0]  second_busy;
  logic [31:0] second_count;
  logic [23:0] second_factor;
  logic [1:0]  event_plate;
  logic [7:0]  event_busy;
  logic [55:0] event_time;
  logic        last;
  modport source (output valid, output result_kind, output block_number,
                  output first_busy, output first_count, output first_factor,
                  output second_busy, output second_count, output second_factor,
                  output event_plate, output event_busy, output event_time,
                  output last, input ready);
  modport sink (input valid, input result_kind, input block_number,
                input first_busy, input first_count, input first_factor,
                input second_busy, input second_count, input second_factor,
                input event_plate, input event_busy, input event_time,
                input last, output ready);
endinterface

/* hw/rtl/dpd_front.sv */
`timescale 1ns / 1ps
// Byte parser: marker tracking, channel assembly, time product and packet-end jobs.
// Depends on dpd_pkg and the in/cfg channel interfaces.
module dpd_front (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  dpd_in_if.sink                 in_ch,
  dpd_cfg_if.sink                cfg_ch,
  input  dpd_pkg::queue_status_t status_i,
  output logic                   push_o,
  output dpd_pkg::job_t          job_o
);

  logic [2:0]  chan_count_q;
  logic        marker_seen_q, marker_seen_d;
  logic        in_packet_q, in_packet_d;
  logic [4:0]  pos_q, pos_d;
  logic [31:0] pkt_count_q, pkt_count_d;
  logic [7:0]  held_q [3];
  logic [7:0]  held_d [3];
  logic [23:0] factor_q [2];
  logic [23:0] factor_d [2];
  logic [7:0]  flag_q [2];
  logic [7:0]  flag_d [2];
  logic [31:0] counter_q [2];
  logic [31:0] counter_d [2];
  logic [55:0] time_q [2];
  logic [55:0] time_d [2];
  logic [7:0]  busy_q [2];
  logic [7:0]  busy_d [2];

  logic        accept, is_marker, double_marker, take, pkt_end;
  logic [1:0]  chan, sub;
  logic        plate;
  logic [2:0]  eff;
  logic [4:0]  end_pos, pos_inc;
  logic [31:0] counter_new;
  logic [55:0] product;

  assign in_ch.ready  = !status_i.full;
  assign cfg_ch.ready = 1'b1;

  assign accept        = in_ch.valid && in_ch.ready;
  assign is_marker     = (in_ch.data_byte == dpd_pkg::MarkerByte);
  assign double_marker = is_marker && marker_seen_q;
  assign take          = accept && in_packet_q && !double_marker;
  assign chan          = pos_q[3:2];
  assign sub           = pos_q[1:0];
  assign plate         = chan[1];
  assign pos_inc       = pos_q + 5'd1;
  assign end_pos       = {eff, 2'b00};
  assign pkt_end       = take && (pos_inc == end_pos);
  assign counter_new   = {in_ch.data_byte, held_q[2], held_q[1], held_q[0]};
  assign product       = 56'(counter_new) * 56'(factor_q[plate]);

  always_comb begin
    case (chan_count_q) inside
      3'd1, 3'd2, 3'd3, 3'd4: eff = chan_count_q;
      3'd0:                   eff = 3'd1;
      default:                eff = 3'd4;
    endcase
  end

  always_comb begin
    held_d      = held_q;
    factor_d    = factor_q;
    flag_d      = flag_q;
    counter_d   = counter_q;
    time_d      = time_q;
    busy_d      = busy_q;
    pkt_count_d = pkt_count_q;
    marker_seen_d = marker_seen_q;
    in_packet_d = in_packet_q;
    pos_d       = pos_q;
    if (accept) begin
      if (double_marker) begin
        marker_seen_d = 1'b0;
        in_packet_d   = 1'b1;
        pos_d         = '0;
      end else begin
        marker_seen_d = is_marker;
      end
    end
    if (take) begin
      pos_d = pos_inc;
      case (sub)
        2'd0: held_d[0] = in_ch.data_byte;
        2'd1: held_d[1] = in_ch.data_byte;
        2'd2: held_d[2] = in_ch.data_byte;
        default: begin
          if (chan[0]) begin
            counter_d[plate] = counter_new;
            time_d[plate]    = product;
          end else begin
            factor_d[plate] = {held_q[0], held_q[1], held_q[2]};
            flag_d[plate]   = in_ch.data_byte;
          end
        end
      endcase
    end
    if (pkt_end) begin
      pkt_count_d = pkt_count_q + 32'd1;
      busy_d      = flag_d;
      in_packet_d = 1'b0;
    end
  end

  assign push_o = (accept && double_marker && in_packet_q) || pkt_end;

  always_comb begin
    job_o.is_error     = !pkt_end;
    job_o.block_number = pkt_count_q + 32'd1;
    job_o.busy0        = busy_q[0];
    job_o.busy1        = busy_q[1];
    job_o.count0       = counter_d[0];
    job_o.count1       = counter_d[1];
    job_o.factor0      = factor_d[0];
    job_o.factor1      = factor_d[1];
    job_o.change0      = (busy_q[0] != flag_d[0]);
    job_o.change1      = (busy_q[1] != flag_d[1]);
    job_o.flag0        = flag_d[0];
    job_o.flag1        = flag_d[1];
    job_o.time0        = time_d[0];
    job_o.time1        = time_d[1];
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      chan_count_q  <= 3'd4;
      marker_seen_q <= 1'b0;
      in_packet_q   <= 1'b0;
      pos_q         <= '0;
      pkt_count_q   <= '0;
      held_q        <= '{default: '0};
      factor_q      <= '{default: '0};
      flag_q        <= '{default: '0};
      counter_q     <= '{default: '0};
      time_q        <= '{default: '0};
      busy_q        <= '{default: '0};
    end else begin
      if (cfg_ch.valid) begin
        chan_count_q <= cfg_ch.data;
      end
      marker_seen_q <= marker_seen_d;
      in_packet_q   <= in_packet_d;
      pos_q         <= pos_d;
      pkt_count_q   <= pkt_count_d;
      held_q        <= held_d;
      factor_q      <= factor_d;
      flag_q        <= flag_d;
      counter_q     <= counter_d;
      time_q        <= time_d;
      busy_q        <= busy_d;
    end
  end

endmodule

/* hw/rtl/dpd_queue.sv */
`timescale 1ns / 1ps
// Short job queue between parser and emitter, registered entries.
// Depends on dpd_pkg for the entry type and depth.
module dpd_queue (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  logic                   push_i,
  input  dpd_pkg::job_t          job_i,
  input  logic                   pop_i,
  output dpd_pkg::job_t          head_o,
  output dpd_pkg::queue_status_t status_o
);

  dpd_pkg::job_t mem_q [dpd_pkg::QueueDepth];
  logic [dpd_pkg::QueueAw-1:0] wr_ptr_q, rd_ptr_q;
  logic [dpd_pkg::QueueAw:0]   fill_q;

  assign head_o             = mem_q[rd_ptr_q];
  assign status_o.not_empty = (fill_q != '0);
  assign status_o.full      = (fill_q == (dpd_pkg::QueueAw+1)'(dpd_pkg::QueueDepth));

  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_ptr_q] <= job_i;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_ptr_q <= '0;
      rd_ptr_q <= '0;
      fill_q   <= '0;
    end else begin
      if (push_i) begin
        wr_ptr_q <= wr_ptr_q + 1'b1;
      end
      if (pop_i) begin
        rd_ptr_q <= rd_ptr_q + 1'b1;
      end
      case ({push_i, pop_i})
        2'b10:   fill_q <= fill_q + 1'b1;
        2'b01:   fill_q <= fill_q - 1'b1;
        default: fill_q <= fill_q;
      endcase
    end
  end

endmodule

/* hw/rtl/dpd_back.sv */
`timescale 1ns / 1ps
// Result emitter: expands each job into its record, change events or error beat.
// Depends on dpd_pkg and the out channel interface.
module dpd_back (
  input  logic                   clk_i,
  input  logic                   rst_ni,
  input  dpd_pkg::job_t          head_i,
  input  dpd_pkg::queue_status_t status_i,
  output logic                   pop_o,
  dpd_out_if.source              out_ch
);

  dpd_pkg::phase_e phase_q, phase_d;
  dpd_pkg::res_t   beat, res_q;
  logic            out_valid_q, load;

  assign load  = status_i.not_empty && (!out_valid_q || out_ch.ready);
  assign pop_o = load && beat.last;

  always_comb begin
    beat             = '0;
    beat.result_kind = dpd_pkg::KIND_BLOCK;
    phase_d          = phase_q;
    if (head_i.is_error) begin
      beat.result_kind = dpd_pkg::KIND_ERROR;
      beat.last        = 1'b1;
    end else begin
      unique case (phase_q)
        dpd_pkg::PH_RECORD: begin
          beat.result_kind   = dpd_pkg::KIND_BLOCK;
          beat.block_number  = head_i.block_number;
          beat.first_busy    = head_i.busy0;
          beat.first_count   = head_i.count0;
          beat.first_factor  = head_i.factor0;
          beat.second_busy   = head_i.busy1;
          beat.second_count  = head_i.count1;
          beat.second_factor = head_i.factor1;
          beat.last          = !head_i.change0 && !head_i.change1;
        end
        dpd_pkg::PH_FIRST: begin
          beat.result_kind = dpd_pkg::KIND_EVENT;
          beat.event_plate = dpd_pkg::PlateOne;
          beat.event_busy  = head_i.flag0;
          beat.event_time  = head_i.time0;
          beat.last        = !head_i.change1;
        end
        default: begin
          beat.result_kind = dpd_pkg::KIND_EVENT;
          beat.event_plate = dpd_pkg::PlateTwo;
          beat.event_busy  = head_i.flag1;
          beat.event_time  = head_i.time1;
          beat.last        = 1'b1;
        end
      endcase
    end
    if (load) begin
      if (beat.last) begin
        phase_d = dpd_pkg::PH_RECORD;
      end else if (phase_q == dpd_pkg::PH_RECORD && head_i.change0) begin
        phase_d = dpd_pkg::PH_FIRST;
      end else begin
        phase_d = dpd_pkg::PH_SECOND;
      end
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      phase_q     <= dpd_pkg::PH_RECORD;
      out_valid_q <= 1'b0;
    end else begin
      phase_q <= phase_d;
      if (load) begin
        out_valid_q <= 1'b1;
      end else if (out_ch.ready) begin
        out_valid_q <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk_i) begin
    if (load) begin
      res_q <= beat;
    end
  end

  assign out_ch.valid         = out_valid_q;
  assign out_ch.result_kind   = res_q.result_kind;
  assign out_ch.block_number  = res_q.block_number;
  assign out_ch.first_busy    = res_q.first_busy;
  assign out_ch.first_count   = res_q.first_count;
  assign out_ch.first_factor  = res_q.first_factor;
  assign out_ch.second_busy   = res_q.second_busy;
  assign out_ch.second_count  = res_q.second_count;
  assign out_ch.second_factor = res_q.second_factor;
  assign out_ch.event_plate   = res_q.event_plate;
  assign out_ch.event_busy    = res_q.event_busy;
  assign out_ch.event_time    = res_q.event_time;
  assign out_ch.last          = res_q.last;

endmodule

/* hw/rtl/dual_plate_packet_deframer.sv */
`timescale 1ns / 1ps
// Top level of the dual-plate packet deframer: parser, job queue, result emitter.
// Depends on dpd_pkg, dpd_if, dpd_front, dpd_queue and dpd_back.
//
//   channel  dir  beat carries
//   in_ch    in   data_byte, one serial byte
//   cfg_ch   in   data, channel_count (3 bits), always ready
//   out_ch   out  one result: record, plate change event or marker error
//
// One byte a cycle; the parser updates all state and forms the time product in that cycle.
// A packet end queues one job, emitted as one to three beats at one beat a cycle.
// Input stalls only when the four-entry job queue is full; output stalls hold the beat.
// Reset clears all state but the queue entries and the output beat register; channel_count returns to four.
module dual_plate_packet_deframer (
  input  logic      clk_i,
  input  logic      rst_ni,
  dpd_in_if.sink    in_ch,
  dpd_cfg_if.sink   cfg_ch,
  dpd_out_if.source out_ch
);

  logic                   push, pop;
  dpd_pkg::job_t          job, head;
  dpd_pkg::queue_status_t status;

  dpd_front u_front (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .in_ch    (in_ch),
    .cfg_ch   (cfg_ch),
    .status_i (status),
    .push_o   (push),
    .job_o    (job)
  );

  dpd_queue u_queue (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .push_i   (push),
    .job_i    (job),
    .pop_i    (pop),
    .head_o   (head),
    .status_o (status)
  );

  dpd_back u_back (
    .clk_i    (clk_i),
    .rst_ni   (rst_ni),
    .head_i   (head),
    .status_i (status),
    .pop_o    (pop),
    .out_ch   (out_ch)
  );

endmodule
